// File: design/vfme_pkg.sv
// Shared types, constants and CRC function for the VAN frame Manchester encoder.
`timescale 1ns / 1ps

package vfme_pkg;

    localparam logic [7:0]  SOF_BYTE     = 8'h0E;
    localparam logic [14:0] CRC_POLY     = 15'h0F9D;
    localparam logic [14:0] CRC_INIT     = 15'h7FFF;
    localparam logic [2:0]  RUN_LEN_MAX  = 3'd7;
    localparam logic [2:0]  EOD_RUN_LEN  = 3'd2;
    localparam logic [3:0]  POS_LAST     = 4'd9;  // Manchester slice after bit 0
    localparam logic [3:0]  POS_TAIL_END = 4'd7;  // bit 1 of the truncated CRC byte

    // Configuration register indexes
    localparam logic [1:0] CFG_ADD_SOF = 2'd0;
    localparam logic [1:0] CFG_ADD_CRC = 2'd1;
    localparam logic [1:0] CFG_ADD_EOD = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       line_level;
        logic [2:0] duration_slices;
        logic       end_of_frame;
    } out_item_t;

    typedef struct packed {
        logic add_start_of_frame;
        logic add_crc;
        logic add_end_of_data;
    } cfg_t;

    // One classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        send_sof;
        logic        send_crc;
        logic        send_eod;
        logic [15:0] crc_word;
    } job_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SOF   = 7'b0000010,
        ST_DATA  = 7'b0000100,
        ST_CRCH  = 7'b0001000,
        ST_CRCL  = 7'b0010000,
        ST_FLUSH = 7'b0100000,
        ST_EOD   = 7'b1000000
    } back_state_t;

    function automatic logic [14:0] crc15_byte(input logic [14:0] crc_in,
                                               input logic [7:0] b);
        logic [14:0] c;
        logic        fb;
        c = crc_in;
        for (int j = 7; j >= 0; j--) begin
            fb = c[14] ^ b[j];
            c  = {c[13:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: design/vfme_front.sv
// Front end: accepts frame bytes, runs the CRC-15 and builds queue jobs.
`timescale 1ns / 1ps

module vfme_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vfme_pkg::in_item_t s_data,
    input  vfme_pkg::cfg_t    cfg,
    input  logic              q_ready,
    output logic              q_push,
    output vfme_pkg::job_t    q_job
);
    import vfme_pkg::*;

    logic [14:0] crc_reg;
    logic [14:0] crc_next;
    logic [14:0] crc_base;
    logic [14:0] crc_upd;

    assign s_ready  = q_ready;
    assign q_push   = s_valid && q_ready;
    assign crc_base = s_data.first_byte ? CRC_INIT : crc_reg;
    assign crc_upd  = crc15_byte(crc_base, s_data.data_byte);

    always_comb begin
        crc_next = crc_reg;
        if (q_push) begin
            crc_next = s_data.last_byte ? CRC_INIT : crc_upd;
        end
    end

    always_comb begin
        q_job.data_byte  = s_data.data_byte;
        q_job.first_byte = s_data.first_byte;
        q_job.last_byte  = s_data.last_byte;
        q_job.send_sof   = s_data.first_byte && cfg.add_start_of_frame;
        q_job.send_crc   = cfg.add_crc;
        q_job.send_eod   = cfg.add_end_of_data;
        q_job.crc_word   = {crc_upd ^ CRC_INIT, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

// File: design/vfme_queue.sv
// Short job queue between front and back.
`timescale 1ns / 1ps

module vfme_queue #(
    parameter int Depth = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vfme_pkg::job_t push_job,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output vfme_pkg::job_t head_job
);
    import vfme_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    job_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign ready    = count_reg != CntFull;
    assign valid    = count_reg != '0;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CntW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CntW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/vfme_back.sv
// Back end: slice sequencer, run merger and output register.
`timescale 1ns / 1ps

module vfme_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  vfme_pkg::job_t     q_job,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vfme_pkg::out_item_t m_data
);
    import vfme_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [3:0]  pos_reg, pos_next;
    logic        run_open_reg, run_open_next;
    logic        run_lvl_reg, run_lvl_next;
    logic [2:0]  run_len_reg, run_len_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic [7:0]  cur_byte;
    logic        slice_lvl;
    logic        seg_done;
    logic        step_en;
    logic        load_req;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (state_reg)
            ST_SOF:  cur_byte = SOF_BYTE;
            ST_CRCH: cur_byte = job_reg.crc_word[15:8];
            ST_CRCL: cur_byte = job_reg.crc_word[7:0];
            default: cur_byte = job_reg.data_byte;
        endcase
    end

    // slice order: b7 b6 b5 b4 ~b4 b3 b2 b1 b0 ~b0
    always_comb begin
        case (pos_reg)
            4'd0:    slice_lvl = cur_byte[7];
            4'd1:    slice_lvl = cur_byte[6];
            4'd2:    slice_lvl = cur_byte[5];
            4'd3:    slice_lvl = cur_byte[4];
            4'd4:    slice_lvl = ~cur_byte[4];
            4'd5:    slice_lvl = cur_byte[3];
            4'd6:    slice_lvl = cur_byte[2];
            4'd7:    slice_lvl = cur_byte[1];
            4'd8:    slice_lvl = cur_byte[0];
            default: slice_lvl = ~cur_byte[0];
        endcase
    end

    assign seg_done = (state_reg == ST_CRCL) ? (pos_reg == POS_TAIL_END)
                                             : (pos_reg == POS_LAST);
    assign step_en  = (state_reg != ST_IDLE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        pos_next       = pos_reg;
        run_open_next  = run_open_reg;
        run_lvl_next   = run_lvl_reg;
        run_len_next   = run_len_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        load_req       = (state_reg == ST_IDLE);
        q_pop          = 1'b0;

        if (step_en) begin
            case (state_reg)
                ST_SOF, ST_DATA, ST_CRCH, ST_CRCL: begin
                    if (run_open_reg && slice_lvl == run_lvl_reg &&
                        run_len_reg < RUN_LEN_MAX) begin
                        run_len_next = 3'(run_len_reg + 3'd1);
                    end else begin
                        if (run_open_reg) begin
                            out_valid_next           = 1'b1;
                            out_next.line_level      = run_lvl_reg;
                            out_next.duration_slices = run_len_reg;
                            out_next.end_of_frame    = 1'b0;
                        end
                        run_open_next = 1'b1;
                        run_lvl_next  = slice_lvl;
                        run_len_next  = 3'd1;
                    end
                    if (seg_done) begin
                        pos_next = '0;
                        case (state_reg)
                            ST_SOF:  state_next = ST_DATA;
                            ST_DATA: begin
                                if (!job_reg.last_byte) begin
                                    load_req = 1'b1;
                                end else if (job_reg.send_crc) begin
                                    state_next = ST_CRCH;
                                end else begin
                                    state_next = ST_FLUSH;
                                end
                            end
                            ST_CRCH: state_next = ST_CRCL;
                            default: state_next = ST_FLUSH;
                        endcase
                    end else begin
                        pos_next = 4'(pos_reg + 4'd1);
                    end
                end
                ST_FLUSH: begin
                    if (run_open_reg) begin
                        out_valid_next           = 1'b1;
                        out_next.line_level      = run_lvl_reg;
                        out_next.duration_slices = run_len_reg;
                        out_next.end_of_frame    = !job_reg.send_eod;
                    end
                    run_open_next = 1'b0;
                    run_lvl_next  = 1'b0;
                    run_len_next  = '0;
                    if (job_reg.send_eod) begin
                        state_next = ST_EOD;
                    end else begin
                        load_req = 1'b1;
                    end
                end
                ST_EOD: begin
                    out_valid_next           = 1'b1;
                    out_next.line_level      = 1'b0;
                    out_next.duration_slices = EOD_RUN_LEN;
                    out_next.end_of_frame    = 1'b1;
                    load_req                 = 1'b1;
                end
                default: begin
                    load_req = 1'b1;
                end
            endcase
        end

        if (load_req) begin
            if (q_valid) begin
                q_pop      = 1'b1;
                job_next   = q_job;
                pos_next   = '0;
                state_next = q_job.send_sof ? ST_SOF : ST_DATA;
                if (q_job.first_byte) begin
                    // a run left open by an unfinished frame is dropped
                    run_open_next = 1'b0;
                    run_lvl_next  = 1'b0;
                    run_len_next  = '0;
                end
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        pos_reg <= pos_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_open_reg  <= 1'b0;
            run_lvl_reg   <= 1'b0;
            run_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_open_reg  <= run_open_next;
            run_lvl_reg   <= run_lvl_next;
            run_len_reg   <= run_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/van_frame_manchester_encoder.sv
// Throughput: the back end encodes one slice per cycle unless the output stalls; a data
//   byte is 10 slices, the start byte 10, the CRC 18; flush and end of data take a step each.
// Input is taken every cycle while the job queue has room.
// Reset (aresetn low, synchronous): queue empty, no run open, CRC 0x7FFF,
//   all three configuration bits set.
`timescale 1ns / 1ps

module van_frame_manchester_encoder #(
    parameter int QueueDepth = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    // frame byte input
    input  logic                s_valid,
    output logic                s_ready,
    input  vfme_pkg::in_item_t  s_data,
    // run output
    output logic                m_valid,
    input  logic                m_ready,
    output vfme_pkg::out_item_t m_data,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic                cfg_data
);
    import vfme_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_ready, q_push, q_valid, q_pop;
    job_t push_job, head_job;

    // Configuration: always ready, unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ADD_SOF: cfg_next.add_start_of_frame = cfg_data;
                CFG_ADD_CRC: cfg_next.add_crc            = cfg_data;
                CFG_ADD_EOD: cfg_next.add_end_of_data    = cfg_data;
                default:     cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accepts a transaction, updates the CRC and tags the job with
    // what this byte adds to the frame (start byte, CRC, end of data).
    vfme_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    // Queue decouples the byte rate from the slice rate.
    vfme_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job)
    );

    // Back: walks the slices, merges equal levels into runs and registers
    // each closed run for the output transaction.
    vfme_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
